// ----- hw/rtl/bpms_pkg.sv -----
// Package for the bit-parallel match statistics core.
// Request codes, sizes and the front-to-back queue entry type. No dependencies.
package bpms_pkg;

  localparam int unsigned MaxPattern   = 64;
  localparam int unsigned ColDepth     = MaxPattern + 1;
  localparam int unsigned ColAddrW     = $clog2(ColDepth);
  localparam int unsigned PosIdxW      = $clog2(MaxPattern);
  localparam int unsigned LenW         = 7;
  localparam int unsigned BoundW       = 32;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned FifoDepth    = 2;

  typedef enum logic [1:0] {
    ReqInit    = 2'd0,
    ReqAdvance = 2'd1,
    ReqStep    = 2'd2,
    ReqExtract = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CfgPatLen = 3'd0,
    CfgMask0  = 3'd1,
    CfgMask1  = 3'd2,
    CfgMask2  = 3'd3,
    CfgMask3  = 3'd4
  } cfg_idx_e;

  // Back-end executor states.
  typedef enum logic [1:0] {StIdle, StRead, StExec, StExtract} st_e;

  // Classified request handed from front to back.
  typedef struct packed {
    req_e                req;
    logic                in_range;   // depth 1..MaxPattern (advance), 0..MaxPattern (step)
    logic [LenW-1:0]     depth;
    logic [MaxPattern-1:0] mask;     // pre-shifted symbol mask for advance
    logic [BoundW-1:0]   lb;
    logic [BoundW-1:0]   rb;
  } cmd_t;

endpackage

// ----- hw/rtl/bpms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/bpms_front.sv -----
// Front end: accepts requests, classifies them and shifts the symbol mask.
// Depends on bpms_pkg.
module bpms_front import bpms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output logic [LenW-1:0]       pat_len_o,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [1:0]            symbol_i,
  input  logic [LenW-1:0]       depth_i,
  input  logic [BoundW-1:0]     left_bound_i,
  input  logic [BoundW-1:0]     right_bound_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output cmd_t                  cmd_o
);

  logic [LenW-1:0]       pat_len_q;
  logic [MaxPattern-1:0] mask_q [4];
  cmd_t                  fifo_q [FifoDepth];
  logic                  rd_ptr_q, wr_ptr_q;
  logic [1:0]            cnt_q;
  cmd_t                  cmd_in;
  logic                  push, pop;
  logic [MaxPattern-1:0] sel_mask;
  logic [PosIdxW-1:0]    shamt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= LenW'(MaxPattern);
      for (int k = 0; k < 4; k++) mask_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPatLen: pat_len_q <= cfg_data_i[LenW-1:0];
        CfgMask0:  mask_q[0] <= cfg_data_i;
        CfgMask1:  mask_q[1] <= cfg_data_i;
        CfgMask2:  mask_q[2] <= cfg_data_i;
        CfgMask3:  mask_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pat_len_o = pat_len_q;

  always_comb begin
    sel_mask        = mask_q[symbol_i];
    shamt           = PosIdxW'(depth_i - LenW'(1));
    cmd_in.req      = req_e'(req_type_i);
    cmd_in.depth    = depth_i;
    cmd_in.lb       = left_bound_i;
    cmd_in.rb       = right_bound_i;
    cmd_in.mask     = sel_mask >> shamt;
    if (req_e'(req_type_i) == ReqAdvance) begin
      cmd_in.in_range = (depth_i != '0) && (depth_i <= LenW'(MaxPattern));
    end else begin
      cmd_in.in_range = (depth_i <= LenW'(MaxPattern));
    end
  end

  assign in_ready_o  = (cnt_q != 2'(FifoDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hw/rtl/bpms_back.sv -----
// Back end: column stack memory, per-position statistics and result stream.
// Depends on bpms_pkg and bpms_ram.
module bpms_back import bpms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [LenW-1:0]     pat_len_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_t                cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                continue_walk_o,
  output logic [PosIdxW-1:0]  pos_index_o,
  output logic [LenW-1:0]     match_length_o,
  output logic [BoundW-1:0]   witness_left_o,
  output logic [BoundW-1:0]   witness_right_o,
  output logic                last_o
);

  st_e                   st_q, st_d;
  cmd_t                  cmd_q;
  logic [LenW-1:0]       best_q  [MaxPattern];
  logic [BoundW-1:0]     wl_q    [MaxPattern];
  logic [BoundW-1:0]     wr_q    [MaxPattern];
  logic [LenW-1:0]       len;
  logic [LenW-1:0]       idx_q, idx_d;
  logic                  ram_we;
  logic [ColAddrW-1:0]   ram_waddr, ram_raddr;
  logic [MaxPattern-1:0] ram_wdata, ram_rdata;
  logic                  out_free;
  logic                  load_cmd, do_init, do_step, emit_step, emit_ext;

  // Output register
  logic                  ov_q, cw_q, last_q;
  logic [PosIdxW-1:0]    pi_q;
  logic [LenW-1:0]       ml_q;
  logic [BoundW-1:0]     ol_q, or_q;

  assign len = (pat_len_i > LenW'(MaxPattern)) ? LenW'(MaxPattern) : pat_len_i;

  bpms_ram #(.Width(MaxPattern), .Depth(ColDepth)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    load_cmd  = 1'b0;
    do_init   = 1'b0;
    do_step   = 1'b0;
    emit_step = 1'b0;
    emit_ext  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ColAddrW'(cmd_q.depth);
    ram_wdata = ram_rdata & cmd_q.mask;
    ram_raddr = ColAddrW'(cmd_q.depth);
    unique case (st_q)
      StIdle: begin
        if (cmd_valid_i) begin
          load_cmd = 1'b1;
          unique case (cmd_i.req)
            ReqInit: begin
              do_init   = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = '1;
            end
            ReqAdvance: if (cmd_i.in_range) st_d = StRead;
            ReqStep: st_d = StRead;
            ReqExtract: begin
              idx_d = '0;
              if (len != '0) st_d = StExtract;
            end
            default: ;
          endcase
        end
      end
      StRead: begin
        // Column read issued; data valid next cycle.
        ram_raddr = (cmd_q.req == ReqAdvance) ? ColAddrW'(cmd_q.depth - LenW'(1))
                                              : ColAddrW'(cmd_q.depth);
        st_d = StExec;
      end
      StExec: begin
        if (cmd_q.req == ReqAdvance) begin
          ram_we = 1'b1;
          st_d   = StIdle;
        end else if (out_free) begin
          do_step   = cmd_q.in_range;
          emit_step = 1'b1;
          st_d      = StIdle;
        end
      end
      StExtract: begin
        if (out_free) begin
          emit_ext = 1'b1;
          idx_d    = idx_q + LenW'(1);
          if (idx_q + LenW'(1) == len) st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // Hold the read address in StRead stable: the RAM registers it at the edge.
  assign cmd_ready_o = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      if (emit_step || emit_ext) ov_q <= 1'b1;
      else if (out_ready_i)      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cmd) cmd_q <= cmd_i;
    if (emit_step) begin
      cw_q   <= cmd_q.in_range && (ram_rdata != '0);
      pi_q   <= '0;
      ml_q   <= '0;
      ol_q   <= '0;
      or_q   <= '0;
      last_q <= 1'b1;
    end else if (emit_ext) begin
      cw_q   <= 1'b0;
      pi_q   <= idx_q[PosIdxW-1:0];
      ml_q   <= best_q[idx_q[PosIdxW-1:0]];
      ol_q   <= wl_q[idx_q[PosIdxW-1:0]];
      or_q   <= wr_q[idx_q[PosIdxW-1:0]];
      last_q <= (idx_q + LenW'(1) == len);
    end
  end

  // Per-position statistics: every lane below the pattern length updates in parallel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxPattern; k++) begin
        best_q[k] <= '0;
        wl_q[k]   <= '0;
        wr_q[k]   <= '0;
      end
    end else begin
      for (int k = 0; k < MaxPattern; k++) begin
        if (do_init && (LenW'(k) < len)) begin
          best_q[k] <= '0;
          wl_q[k]   <= '0;
          wr_q[k]   <= '0;
        end else if (do_step && ram_rdata[k] && (LenW'(k) < len) &&
                     (best_q[k] < cmd_q.depth)) begin
          best_q[k] <= cmd_q.depth;
          wl_q[k]   <= cmd_q.lb;
          wr_q[k]   <= cmd_q.rb;
        end
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign continue_walk_o = cw_q;
  assign pos_index_o     = pi_q;
  assign match_length_o  = ml_q;
  assign witness_left_o  = ol_q;
  assign witness_right_o = or_q;
  assign last_o          = last_q;

endmodule

// ----- hw/rtl/bit_parallel_match_statistics_core.sv -----
// Bit-parallel match statistics core: front classifier, 2-entry queue, back executor.
// Init writes column 0; advance is a column RAM read then write; step is a column read
// plus output wait; extract streams L entries, one entry per cycle from the output
// register while out_ready_i is high. A new request is taken only in StIdle.
// Reset (async, active low) clears statistics, masks and sets pattern_length to 64;
// the column stack is undefined until an init or advance writes it.
module bit_parallel_match_statistics_core import bpms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic [1:0]          symbol_i,
  input  logic [LenW-1:0]     depth_i,
  input  logic [BoundW-1:0]   left_bound_i,
  input  logic [BoundW-1:0]   right_bound_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                continue_walk_o,
  output logic [PosIdxW-1:0]  pos_index_o,
  output logic [LenW-1:0]     match_length_o,
  output logic [BoundW-1:0]   witness_left_o,
  output logic [BoundW-1:0]   witness_right_o,
  output logic                last_o
);

  logic            cmd_valid, cmd_ready;
  cmd_t            cmd;
  logic [LenW-1:0] pat_len;

  bpms_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pat_len_o   (pat_len),
    .in_valid_i, .in_ready_o, .req_type_i, .symbol_i, .depth_i,
    .left_bound_i, .right_bound_i,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  bpms_back u_back (
    .clk_i, .rst_ni,
    .pat_len_i   (pat_len),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o, .out_ready_i, .continue_walk_o, .pos_index_o,
    .match_length_o, .witness_left_o, .witness_right_o, .last_o
  );

  a_step_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && continue_walk_o |-> last_o && pos_index_o == '0 && match_length_o == '0)
    else $error("step result carries extract fields");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_length_o <= LenW'(MaxPattern))
    else $error("match length above pattern size");

  a_ext_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o && !continue_walk_o ##1 out_valid_o
    |-> pos_index_o == $past(pos_index_o) + PosIdxW'(1))
    else $error("extract positions out of order");

endmodule
